@@ rtl/pmfs_pkg.sv @@
package pmfs_pkg;

  localparam int MAX_DATA_WORDS = 64;
  localparam int WORD_BITS      = 64;
  localparam int SHIFT_BITS     = 64;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int COUNT_BITS     = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_PATTERN    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_MASK       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_LENGTH     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WORD_LENGTH     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BITS_PER_FRAME  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WORDS_PER_FRAME = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SYNCS       = 3'd6;

  localparam logic [6:0]  RST_SYNC_LENGTH     = 7'd32;
  localparam logic [6:0]  RST_WORD_LENGTH     = 7'd16;
  localparam logic [15:0] RST_BITS_PER_FRAME  = 16'd1024;
  localparam logic [6:0]  RST_WORDS_PER_FRAME = 7'd65;

  localparam logic [16:0] FBC_MAX  = 17'h1FFFF;
  localparam logic [6:0]  BITS_MAX = 7'd64;
  localparam logic [6:0]  WC_MAX   = 7'h7F;

  typedef struct packed {
    logic [SHIFT_BITS-1:0] sync_pattern;
    logic [SHIFT_BITS-1:0] sync_mask;
    logic [6:0]            sync_length;
    logic [6:0]            word_length;
    logic [15:0]           bits_per_frame;
    logic [6:0]            words_per_frame;
    logic [7:0]            min_syncs;
  } cfg_t;

  typedef struct packed {
    logic                  en;
    logic [6:0]            addr;
    logic [SHIFT_BITS-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic       start;
    logic [6:0] count;
  } release_t;

  function automatic logic [SHIFT_BITS-1:0] word_mask(input logic [6:0] wl);
    logic [SHIFT_BITS-1:0] m;
    for (int i = 0; i < SHIFT_BITS; i++) begin
      m[i] = (7'(i) < wl);
    end
    return m;
  endfunction

endpackage

@@ rtl/pmfs_if.sv @@
interface pmfs_bit_if;
  logic valid;
  logic ready;
  logic serial_bit;

  modport source (output valid, output serial_bit, input ready);
  modport sink   (input valid, input serial_bit, output ready);
endinterface

interface pmfs_word_if;
  logic                                valid;
  logic                                ready;
  logic [pmfs_pkg::SHIFT_BITS-1:0]     data_word;
  logic [5:0]                          word_index;
  logic                                last_word;
  logic [pmfs_pkg::COUNT_BITS-1:0]     good_sync_count;
  logic [pmfs_pkg::COUNT_BITS-1:0]     sync_error_count;

  modport source (output valid, output data_word, output word_index, output last_word,
                  output good_sync_count, output sync_error_count, input ready);
  modport sink   (input valid, input data_word, input word_index, input last_word,
                  input good_sync_count, input sync_error_count, output ready);
endinterface

@@ rtl/pcm_minor_frame_sync.sv @@
// PCM minor frame synchronizer. Serial bits arrive one at a time on the bits channel,
// most significant bit first, and are taken only while no burst is in progress. Data
// words are written into a frame store memory of MAX_DATA_WORDS entries. When a sync
// lands exactly one frame length after the previous one, a full frame is collected and
// the good-sync count has reached min_syncs, the stored frame leaves on the words
// channel; each word passes a memory read state and an output state that holds while
// the output stalls, and the bits channel is held off until the last word is taken.
// There is no clearing pass after reset. Configuration registers are written through
// write_en, reg_index and write_data and must only change while no burst is in progress.
module pcm_minor_frame_sync #(
  parameter int MAX_DATA_WORDS = pmfs_pkg::MAX_DATA_WORDS,
  parameter int WORD_BITS      = pmfs_pkg::WORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  write_en,
  input  logic [pmfs_pkg::CFG_IDX_BITS-1:0]     reg_index,
  input  logic [pmfs_pkg::CFG_DATA_BITS-1:0]    write_data,
  pmfs_bit_if.sink                              bits,
  pmfs_word_if.source                           words
);

  pmfs_pkg::cfg_t      cfg;
  pmfs_pkg::store_wr_t wr;
  pmfs_pkg::release_t  rel;
  logic [pmfs_pkg::COUNT_BITS-1:0] good_sync_count;
  logic [pmfs_pkg::COUNT_BITS-1:0] sync_error_count;
  logic busy;
  logic step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_pattern    <= '0;
      cfg.sync_mask       <= '0;
      cfg.sync_length     <= pmfs_pkg::RST_SYNC_LENGTH;
      cfg.word_length     <= pmfs_pkg::RST_WORD_LENGTH;
      cfg.bits_per_frame  <= pmfs_pkg::RST_BITS_PER_FRAME;
      cfg.words_per_frame <= pmfs_pkg::RST_WORDS_PER_FRAME;
      cfg.min_syncs       <= '0;
    end else if (write_en) begin
      case (reg_index)
        pmfs_pkg::REG_SYNC_PATTERN:    cfg.sync_pattern    <= write_data;
        pmfs_pkg::REG_SYNC_MASK:       cfg.sync_mask       <= write_data;
        pmfs_pkg::REG_SYNC_LENGTH:     cfg.sync_length     <= write_data[6:0];
        pmfs_pkg::REG_WORD_LENGTH:     cfg.word_length     <= write_data[6:0];
        pmfs_pkg::REG_BITS_PER_FRAME:  cfg.bits_per_frame  <= write_data[15:0];
        pmfs_pkg::REG_WORDS_PER_FRAME: cfg.words_per_frame <= write_data[6:0];
        pmfs_pkg::REG_MIN_SYNCS:       cfg.min_syncs       <= write_data[7:0];
        default: ;
      endcase
    end
  end

  assign bits.ready = !busy;
  assign step       = bits.valid && bits.ready;

  pmfs_tracker #(
    .MAX_DATA_WORDS(MAX_DATA_WORDS)
  ) u_tracker (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .step             (step),
    .serial_bit       (bits.serial_bit),
    .wr               (wr),
    .rel              (rel),
    .good_sync_count  (good_sync_count),
    .sync_error_count (sync_error_count)
  );

  pmfs_burst #(
    .MAX_DATA_WORDS(MAX_DATA_WORDS),
    .WORD_BITS     (WORD_BITS)
  ) u_burst (
    .clk              (clk),
    .rst              (rst),
    .wr               (wr),
    .rel              (rel),
    .word_length      (cfg.word_length),
    .good_sync_count  (good_sync_count),
    .sync_error_count (sync_error_count),
    .busy             (busy),
    .words            (words)
  );

  a_no_bits_during_burst: assert property (@(posedge clk) disable iff (rst)
    !(words.valid && bits.ready))
    else $error("bits accepted while a burst is on the output");

  a_burst_ends: assert property (@(posedge clk) disable iff (rst)
    (words.valid && words.ready && words.last_word) |=> !words.valid)
    else $error("output still valid after the final word of a burst");

  a_errors_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (sync_error_count >= $past(sync_error_count)))
    else $error("sync error count went down");

  a_release_needs_step: assert property (@(posedge clk) disable iff (rst)
    rel.start |-> (step && !busy))
    else $error("frame release without an accepted bit");

endmodule

@@ rtl/pmfs_tracker.sv @@
module pmfs_tracker #(
  parameter int MAX_DATA_WORDS = pmfs_pkg::MAX_DATA_WORDS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pmfs_pkg::cfg_t                    cfg,
  input  logic                              step,
  input  logic                              serial_bit,
  output pmfs_pkg::store_wr_t               wr,
  output pmfs_pkg::release_t                rel,
  output logic [pmfs_pkg::COUNT_BITS-1:0]   good_sync_count,
  output logic [pmfs_pkg::COUNT_BITS-1:0]   sync_error_count
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_COLLECT = 2'd1;
  localparam logic [1:0] MODE_FULL    = 2'd2;
  localparam logic [6:0] MAX_WORDS    = 7'(MAX_DATA_WORDS);

  logic [pmfs_pkg::SHIFT_BITS-1:0] shift_word, shift_word_next;
  logic [6:0]  bits_seen, bits_seen_next;
  logic [16:0] frame_bit_count, frame_bit_count_next;
  logic [6:0]  word_count, word_count_next;
  logic [6:0]  word_bit_count, word_bit_count_next;
  logic [1:0]  mode, mode_next;
  logic [pmfs_pkg::COUNT_BITS-1:0] sync_counter, sync_counter_next;
  logic [pmfs_pkg::COUNT_BITS-1:0] error_counter, error_counter_next;

  logic [pmfs_pkg::COUNT_BITS-1:0] sync_inc;
  logic [6:0] wbc_inc;
  logic [6:0] burst_len;
  logic       hit;

  always_comb begin
    shift_word_next      = {shift_word[pmfs_pkg::SHIFT_BITS-2:0], serial_bit};
    bits_seen_next       = (bits_seen < pmfs_pkg::BITS_MAX) ? bits_seen + 7'd1 : bits_seen;
    frame_bit_count_next = (frame_bit_count < pmfs_pkg::FBC_MAX) ?
                           frame_bit_count + 17'd1 : frame_bit_count;
    word_count_next      = word_count;
    word_bit_count_next  = word_bit_count;
    mode_next            = mode;
    sync_counter_next    = sync_counter;
    error_counter_next   = error_counter;
    sync_inc             = sync_counter + 32'd1;
    wbc_inc              = word_bit_count + 7'd1;
    burst_len            = (cfg.words_per_frame == 7'd0) ? 7'd0 : cfg.words_per_frame - 7'd1;
    if (burst_len > MAX_WORDS) begin
      burst_len = MAX_WORDS;
    end
    hit = (bits_seen_next >= cfg.sync_length) &&
          ((shift_word_next & cfg.sync_mask) == cfg.sync_pattern);
    wr.en     = 1'b0;
    wr.addr   = word_count - 7'd1;
    wr.data   = shift_word_next & pmfs_pkg::word_mask(cfg.word_length);
    rel.start = 1'b0;
    rel.count = burst_len;

    if (hit) begin
      word_count_next      = 7'd1;
      word_bit_count_next  = 7'd0;
      mode_next            = MODE_COLLECT;
      if (frame_bit_count_next == {1'b0, cfg.bits_per_frame}) begin
        sync_counter_next = sync_inc;
        rel.start = step && (sync_inc >= {24'd0, cfg.min_syncs}) && (mode == MODE_FULL) &&
                    (burst_len != 7'd0);
      end else begin
        sync_counter_next = '0;
        if ((sync_inc != '0) && (error_counter != '1)) begin
          error_counter_next = error_counter + 32'd1;
        end
      end
      frame_bit_count_next = 17'd0;
    end else if (mode == MODE_COLLECT) begin
      word_bit_count_next = wbc_inc;
      if (wbc_inc >= cfg.word_length) begin
        wr.en = step && (word_count >= 7'd1) && (wr.addr < MAX_WORDS);
        word_bit_count_next = 7'd0;
        if (word_count < pmfs_pkg::WC_MAX) begin
          word_count_next = word_count + 7'd1;
        end
      end
      if (word_count_next >= cfg.words_per_frame) begin
        mode_next = MODE_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word      <= '0;
      bits_seen       <= '0;
      frame_bit_count <= '0;
      word_count      <= '0;
      word_bit_count  <= '0;
      mode            <= MODE_IDLE;
      sync_counter    <= '1;
      error_counter   <= '0;
    end else if (step) begin
      shift_word      <= shift_word_next;
      bits_seen       <= bits_seen_next;
      frame_bit_count <= frame_bit_count_next;
      word_count      <= word_count_next;
      word_bit_count  <= word_bit_count_next;
      mode            <= mode_next;
      sync_counter    <= sync_counter_next;
      error_counter   <= error_counter_next;
    end
  end

  assign good_sync_count  = sync_counter;
  assign sync_error_count = error_counter;

endmodule

@@ rtl/pmfs_burst.sv @@
module pmfs_burst #(
  parameter int MAX_DATA_WORDS = pmfs_pkg::MAX_DATA_WORDS,
  parameter int WORD_BITS      = pmfs_pkg::WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pmfs_pkg::store_wr_t               wr,
  input  pmfs_pkg::release_t                rel,
  input  logic [6:0]                        word_length,
  input  logic [pmfs_pkg::COUNT_BITS-1:0]   good_sync_count,
  input  logic [pmfs_pkg::COUNT_BITS-1:0]   sync_error_count,
  output logic                              busy,
  pmfs_word_if.source                       words
);

  localparam int AW = (MAX_DATA_WORDS > 1) ? $clog2(MAX_DATA_WORDS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [WORD_BITS-1:0] store [MAX_DATA_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic [1:0]           state, state_next;
  logic [6:0]           idx, idx_next;
  logic [6:0]           count;
  logic                 last;
  logic [pmfs_pkg::SHIFT_BITS-1:0] keep_mask;
  logic [pmfs_pkg::SHIFT_BITS-1:0] out_word;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr[AW-1:0]] <= wr.data[WORD_BITS-1:0];
    end
    if (state == ST_READ) begin
      rdata <= store[idx[AW-1:0]];
    end
  end

  assign last = (idx + 7'd1 == count);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      ST_IDLE: begin
        if (rel.start) begin
          state_next = ST_READ;
          idx_next   = 7'd0;
        end
      end
      ST_READ: state_next = ST_SHOW;
      ST_SHOW: begin
        if (words.ready) begin
          idx_next   = idx + 7'd1;
          state_next = last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
    if (state == ST_IDLE && rel.start) begin
      count <= rel.count;
    end
  end

  always_comb begin
    keep_mask                = pmfs_pkg::word_mask(word_length);
    out_word                 = '0;
    out_word[WORD_BITS-1:0]  = rdata & keep_mask[WORD_BITS-1:0];
  end

  assign busy                   = (state != ST_IDLE);
  assign words.valid            = (state == ST_SHOW);
  assign words.data_word        = out_word;
  assign words.word_index       = idx[5:0];
  assign words.last_word        = last;
  assign words.good_sync_count  = good_sync_count;
  assign words.sync_error_count = sync_error_count;

endmodule

@@ dv/testbench.sv @@
module testbench;

  localparam logic [pmfs_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_ROUNDS = 2;

  typedef enum logic [1:0] {FRAME_IDLE, FRAME_COLLECT, FRAME_FULL} frame_mode_t;
  typedef enum {FRAME_GOOD, FRAME_SHIFTED, FRAME_NOISY} frame_kind_t;
  typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [5:0]  word_index;
    logic        last_word;
    logic [31:0] good_sync_count;
    logic [31:0] sync_error_count;
  } frame_word_t;

  class burst_scoreboard;
    pmfs_pkg::cfg_t cfg;
    logic [63:0]    shift_word;
    int unsigned    bits_seen;
    int unsigned    frame_bits;
    int unsigned    word_count;
    int unsigned    word_bits;
    frame_mode_t    mode;
    logic [31:0]    sync_count;
    logic [31:0]    err_count;
    logic [63:0]    store [64];
    bit             written [64];
    frame_word_t    awaited [$];
    int             faults;

    function new();
      cfg = '0;
      cfg.sync_length = pmfs_pkg::RST_SYNC_LENGTH;
      cfg.word_length = pmfs_pkg::RST_WORD_LENGTH;
      cfg.bits_per_frame = pmfs_pkg::RST_BITS_PER_FRAME;
      cfg.words_per_frame = pmfs_pkg::RST_WORDS_PER_FRAME;
      shift_word = '0;
      bits_seen = 0;
      frame_bits = 0;
      word_count = 0;
      word_bits = 0;
      mode = FRAME_IDLE;
      sync_count = '1;
      err_count = '0;
      faults = 0;
      for (int i = 0; i < 64; i++) begin
        store[i] = '0;
        written[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [pmfs_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] value);
      case (idx)
        pmfs_pkg::REG_SYNC_PATTERN:    cfg.sync_pattern = value;
        pmfs_pkg::REG_SYNC_MASK:       cfg.sync_mask = value;
        pmfs_pkg::REG_SYNC_LENGTH:     cfg.sync_length = value[6:0];
        pmfs_pkg::REG_WORD_LENGTH:     cfg.word_length = value[6:0];
        pmfs_pkg::REG_BITS_PER_FRAME:  cfg.bits_per_frame = value[15:0];
        pmfs_pkg::REG_WORDS_PER_FRAME: cfg.words_per_frame = value[6:0];
        pmfs_pkg::REG_MIN_SYNCS:       cfg.min_syncs = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] kept_bits();
      if (cfg.word_length >= 64) return '1;
      return (64'd1 << cfg.word_length) - 64'd1;
    endfunction

    // A full frame must never be stretched over store entries that were never written.
    function logic [6:0] safe_frame_words(logic [6:0] want);
      int unsigned n;
      if (mode != FRAME_FULL) return want;
      n = (want > 0) ? want - 1 : 0;
      if (n > pmfs_pkg::MAX_DATA_WORDS) n = pmfs_pkg::MAX_DATA_WORDS;
      for (int i = 0; i < n; i++) begin
        if (!written[i]) return cfg.words_per_frame;
      end
      return want;
    endfunction

    function bit would_sync(logic b);
      logic [63:0] shifted;
      int unsigned seen;
      shifted = {shift_word[62:0], b};
      seen = (bits_seen < 64) ? bits_seen + 1 : 64;
      return (seen >= cfg.sync_length) && ((shifted & cfg.sync_mask) == cfg.sync_pattern);
    endfunction

    function void restart_frame(logic [31:0] count);
      frame_bits = 0;
      word_count = 1;
      word_bits = 0;
      sync_count = count;
    endfunction

    function void note_bit(logic b);
      frame_word_t w;
      int unsigned n;
      shift_word = {shift_word[62:0], b};
      if (bits_seen < 64) bits_seen++;
      if (frame_bits < pmfs_pkg::FBC_MAX) frame_bits++;
      if (bits_seen >= cfg.sync_length && (shift_word & cfg.sync_mask) == cfg.sync_pattern) begin
        sync_count++;
        if (frame_bits == cfg.bits_per_frame) begin
          restart_frame(sync_count);
          if (sync_count >= cfg.min_syncs && mode == FRAME_FULL) begin
            n = (cfg.words_per_frame > 0) ? cfg.words_per_frame - 1 : 0;
            if (n > pmfs_pkg::MAX_DATA_WORDS) n = pmfs_pkg::MAX_DATA_WORDS;
            for (int i = 0; i < n; i++) begin
              w.data_word = store[i] & kept_bits();
              w.word_index = 6'(i);
              w.last_word = (i + 1 == n);
              w.good_sync_count = sync_count;
              w.sync_error_count = err_count;
              awaited.push_back(w);
            end
          end
        end else begin
          if (sync_count > 0 && err_count != '1) err_count++;
          restart_frame('0);
        end
        word_bits = 0;
        mode = FRAME_COLLECT;
        return;
      end
      if (mode == FRAME_COLLECT) begin
        word_bits++;
        if (word_bits >= cfg.word_length) begin
          if (word_count >= 1 && word_count - 1 < pmfs_pkg::MAX_DATA_WORDS) begin
            store[word_count - 1] = shift_word & kept_bits();
            written[word_count - 1] = 1'b1;
          end
          word_bits = 0;
          if (word_count < pmfs_pkg::WC_MAX) word_count++;
        end
        if (word_count >= cfg.words_per_frame) mode = FRAME_FULL;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        faults++;
      end
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual data %0h index %0d",
                 $time, got.data_word, got.word_index);
        faults++;
        return;
      end
      want = awaited.pop_front();
      compare_field("data_word", want.data_word, got.data_word);
      compare_field("word_index", want.word_index, got.word_index);
      compare_field("last_word", want.last_word, got.last_word);
      compare_field("good_sync_count", want.good_sync_count, got.good_sync_count);
      compare_field("sync_error_count", want.sync_error_count, got.sync_error_count);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic write_en;
  logic [pmfs_pkg::CFG_IDX_BITS-1:0] reg_index;
  logic [pmfs_pkg::CFG_DATA_BITS-1:0] write_data;

  pmfs_bit_if bits ();
  pmfs_word_if words ();

  pcm_minor_frame_sync dut (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .bits       (bits),
    .words      (words)
  );

  burst_scoreboard sb = new();

  int bit_run = 0;
  bit bit_steady = 1'b0;
  int word_run = 0;
  bit word_steady = 1'b0;
  bit hold_words_long = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1500000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int draw_gap(inout int run, inout bit steady);
    if (run == 0) begin
      steady = ($urandom_range(0, 3) == 0);
      run = $urandom_range(8, 40);
    end
    run--;
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic pmfs_pkg::cfg_t frame_cfg(int sl, int wl, int wpf, int filler,
                                               int min_syncs);
    pmfs_pkg::cfg_t c;
    int span;
    span = (sl > 64) ? 64 : sl;
    c.sync_mask = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
    c.sync_pattern = {$urandom, $urandom} & c.sync_mask;
    c.sync_length = 7'(sl);
    c.word_length = 7'(wl);
    c.words_per_frame = 7'(wpf);
    c.min_syncs = 8'(min_syncs);
    c.bits_per_frame = 16'(((wpf > 1) ? wpf - 1 : 0) * wl + span + filler);
    return c;
  endfunction

  task automatic send_bit(input logic b);
    int gap;
    gap = draw_gap(bit_run, bit_steady);
    if (gap > 0) begin
      bits.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bits.valid <= 1'b1;
    bits.serial_bit <= b;
    @(posedge clk);
    while (!bits.ready) @(posedge clk);
    sb.note_bit(b);
    @(negedge clk);
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) send_bit($urandom_range(0, 1));
  endtask

  task automatic send_sync();
    int span;
    span = (sb.cfg.sync_length > 64) ? 64 : sb.cfg.sync_length;
    for (int i = span - 1; i >= 0; i--) send_bit(sb.cfg.sync_pattern[i]);
  endtask

  task automatic send_frame(input frame_kind_t kind, input fill_t fill);
    int len;
    int span;
    int delta;
    logic b;
    span = (sb.cfg.sync_length > 64) ? 64 : sb.cfg.sync_length;
    len = (sb.cfg.bits_per_frame > span) ? sb.cfg.bits_per_frame - span : 0;
    if (kind == FRAME_SHIFTED) begin
      delta = $urandom_range(1, 4);
      if ($urandom_range(0, 1) == 0 || len < delta) len = len + delta;
      else len = len - delta;
    end
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZEROS: b = 1'b0;
        FILL_ONES:  b = 1'b1;
        default:    b = $urandom_range(0, 1);
      endcase
      if (kind != FRAME_NOISY && sb.would_sync(b)) b = ~b;
      send_bit(b);
    end
    send_sync();
  endtask

  task automatic send_frames(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) send_frame(FRAME_GOOD, FILL_RANDOM);
      else if (pick == 8) send_frame(FRAME_SHIFTED, FILL_RANDOM);
      else send_frame(FRAME_NOISY, FILL_RANDOM);
      if ($urandom_range(0, 15) == 0) send_noise($urandom_range(1, 20));
    end
  endtask

  task automatic settle();
    bits.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input pmfs_pkg::cfg_t c);
    logic [pmfs_pkg::CFG_IDX_BITS-1:0] idx;
    logic [63:0] value;
    c.words_per_frame = sb.safe_frame_words(c.words_per_frame);
    for (int i = 0; i <= REG_UNUSED; i++) begin
      idx = 3'(i);
      case (idx)
        pmfs_pkg::REG_SYNC_PATTERN:    value = c.sync_pattern;
        pmfs_pkg::REG_SYNC_MASK:       value = c.sync_mask;
        pmfs_pkg::REG_SYNC_LENGTH:     value = 64'(c.sync_length);
        pmfs_pkg::REG_WORD_LENGTH:     value = 64'(c.word_length);
        pmfs_pkg::REG_BITS_PER_FRAME:  value = 64'(c.bits_per_frame);
        pmfs_pkg::REG_WORDS_PER_FRAME: value = 64'(c.words_per_frame);
        pmfs_pkg::REG_MIN_SYNCS:       value = 64'(c.min_syncs);
        default:                       value = {$urandom, $urandom};
      endcase
      write_en <= 1'b1;
      reg_index <= idx;
      write_data <= value;
      sb.set_reg(idx, value);
      @(negedge clk);
    end
    write_en <= 1'b0;
  endtask

  initial begin : word_sink
    frame_word_t got;
    int pause;
    words.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      pause = draw_gap(word_run, word_steady);
      if (hold_words_long) begin
        pause = LONG_HOLD;
        hold_words_long = 1'b0;
      end
      if (pause > 0) begin
        words.ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      words.ready <= 1'b1;
      @(posedge clk);
      while (!words.valid) @(posedge clk);
      got = {words.data_word, words.word_index, words.last_word,
             words.good_sync_count, words.sync_error_count};
      sb.check_word(got);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    pmfs_pkg::cfg_t c;
    rst = 1'b1;
    write_en = 1'b0;
    reg_index = '0;
    write_data = '0;
    bits.valid = 1'b0;
    bits.serial_bit = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With the reset settings every bit from the sync length onward matches at a wrong offset.
    send_noise(34);
    settle();

    c = frame_cfg(4, 4, 3, 1, 0);
    configure(c);
    send_sync();
    send_frame(FRAME_GOOD, FILL_ZEROS);
    send_frame(FRAME_GOOD, FILL_ONES);
    send_frame(FRAME_SHIFTED, FILL_RANDOM);
    send_frame(FRAME_GOOD, FILL_RANDOM);
    send_frame(FRAME_NOISY, FILL_RANDOM);
    settle();

    c = frame_cfg(4, 2, 3, 0, 2);
    configure(c);
    send_sync();
    repeat (4) send_frame(FRAME_GOOD, FILL_RANDOM);
    settle();

    c = frame_cfg(64, 4, 2, 0, 0);
    c.sync_mask = '1;
    c.sync_pattern = '1;
    configure(c);
    send_sync();
    send_frame(FRAME_GOOD, FILL_ZEROS);
    settle();

    c = frame_cfg(1, 1, 2, 0, 0);
    configure(c);
    send_sync();
    repeat (5) send_frame(FRAME_GOOD, FILL_RANDOM);
    settle();

    // Zero word length: every collected bit closes a word.
    c = frame_cfg(4, 0, 5, 2, 0);
    configure(c);
    send_sync();
    repeat (3) send_frame(FRAME_GOOD, FILL_RANDOM);
    settle();

    c = frame_cfg(4, 65, 2, 0, 0);
    configure(c);
    send_sync();
    send_frame(FRAME_GOOD, FILL_ONES);
    settle();

    // More words per frame than the store holds: extra writes drop and the bursts are
    // clamped to a full store, while the output side stalls for a long stretch.
    c = frame_cfg(4, 1, 70, 0, 0);
    configure(c);
    hold_words_long = 1'b1;
    send_sync();
    send_frame(FRAME_GOOD, FILL_RANDOM);
    send_frame(FRAME_GOOD, FILL_ONES);
    settle();

    c = frame_cfg(4, 2, 1, 1, 0);
    configure(c);
    send_sync();
    repeat (2) send_frame(FRAME_GOOD, FILL_RANDOM);
    settle();

    c = frame_cfg(4, 2, 0, 1, 0);
    configure(c);
    send_sync();
    repeat (2) send_frame(FRAME_GOOD, FILL_RANDOM);
    settle();

    c = frame_cfg(4, 2, 3, 0, 0);
    c.bits_per_frame = '0;
    configure(c);
    send_sync();
    repeat (3) send_frame(FRAME_GOOD, FILL_RANDOM);
    settle();

    c = frame_cfg(100, 8, 4, 0, 0);
    configure(c);
    send_noise(10);
    settle();

    c = frame_cfg(4, 2, 3, 0, 255);
    c.bits_per_frame = '1;
    configure(c);
    send_sync();
    send_noise(8);
    settle();

    c = frame_cfg(4, 2, 3, 0, 255);
    configure(c);
    send_sync();
    repeat (4) send_frame(FRAME_GOOD, FILL_RANDOM);
    settle();

    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      c = frame_cfg($urandom_range(4, 8), $urandom_range(1, 4), $urandom_range(2, 4),
                    $urandom_range(0, 2), $urandom_range(0, 2));
      configure(c);
      send_sync();
      send_frames($urandom_range(2, 4));
      settle();
    end

    if (sb.faults == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
